/* rtl/core/nkc_pkg.sv */
// Shared constants and types for the nearest-knot curve lookup unit.
package nkc_pkg;

   localparam int MAX_KNOTS = 16;
   localparam int IDX_W     = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
   localparam int VAL_W     = 32;
   localparam int POS_W     = 36;
   localparam int CMP_W     = POS_W + 1;
   localparam int REM_MW    = 34;
   localparam int REM_DW    = REM_MW + 1;
   localparam int CSR_IDX_W = 3;

   localparam logic       CMD_QUERY = 1'b0;
   localparam logic       CMD_WRITE = 1'b1;

   localparam logic [1:0] REGION_INSIDE = 2'd0;
   localparam logic [1:0] REGION_BELOW  = 2'd1;
   localparam logic [1:0] REGION_ABOVE  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_KNOT_COUNT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_MODE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CEIL_MODE      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_CONSTANT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CEIL_CONSTANT  = 3'd4;

   typedef enum logic [1:0] {
      MODE_CLAMP    = 2'd0,
      MODE_CONSTANT = 2'd1,
      MODE_REPEAT   = 2'd2,
      MODE_MIRROR   = 2'd3
   } mode_type;

endpackage

/* rtl/core/nkc_knot_ram.sv */
// Knot table memory: x and y words per slot, one write port, one registered read port.
module nkc_knot_ram (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic        [nkc_pkg::IDX_W-1:0]      wr_addr,
   input  logic signed [nkc_pkg::VAL_W-1:0]      wr_x,
   input  logic signed [nkc_pkg::VAL_W-1:0]      wr_y,
   input  logic        [nkc_pkg::IDX_W-1:0]      rd_addr,
   output logic signed [nkc_pkg::VAL_W-1:0]      rd_x,
   output logic signed [nkc_pkg::VAL_W-1:0]      rd_y
);

   logic signed [nkc_pkg::VAL_W-1:0] x_mem [nkc_pkg::MAX_KNOTS];
   logic signed [nkc_pkg::VAL_W-1:0] y_mem [nkc_pkg::MAX_KNOTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_mem[wr_addr] <= wr_x;
         y_mem[wr_addr] <= wr_y;
      end
      rd_x <= x_mem[rd_addr];
      rd_y <= y_mem[rd_addr];
   end

endmodule

/* rtl/core/nkc_rem_unit.sv */
// Bit-serial truncated remainder: one quotient bit per cycle, sign follows the dividend.
module nkc_rem_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [nkc_pkg::REM_DW-1:0]   dividend,
   input  logic        [nkc_pkg::REM_MW-1:0]   divisor,
   output logic                                done,
   output logic signed [nkc_pkg::REM_DW-1:0]   remainder
);

   localparam int CNT_W = $clog2(nkc_pkg::REM_MW + 1);

   logic                         busy_ff;
   logic                         done_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic [nkc_pkg::REM_MW-1:0]   quo_ff;
   logic [nkc_pkg::REM_MW:0]     rem_ff;
   logic [nkc_pkg::REM_MW-1:0]   div_ff;
   logic                         neg_ff;
   logic [nkc_pkg::REM_DW-1:0]   mag;
   logic [nkc_pkg::REM_MW:0]     trial;
   logic [nkc_pkg::REM_MW:0]     rem_in;

   assign mag   = dividend[nkc_pkg::REM_DW-1] ? -dividend : dividend;
   assign trial = {rem_ff[nkc_pkg::REM_MW-1:0], quo_ff[nkc_pkg::REM_MW-1]};
   assign rem_in = (trial >= {1'b0, div_ff}) ? trial - {1'b0, div_ff} : trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(nkc_pkg::REM_MW);
            quo_ff  <= mag[nkc_pkg::REM_MW-1:0];
            rem_ff  <= '0;
            div_ff  <= divisor;
            neg_ff  <= dividend[nkc_pkg::REM_DW-1];
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_ff << 1;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = neg_ff ? -$signed(rem_ff) : $signed(rem_ff);

endmodule

/* rtl/core/nearest_knot_curve_lookup_unit.sv */
// Top level of the nearest-knot curve lookup unit: sequencer, config registers, output register.
//
// A knot write (cmd 1) stores x and y in the knot memory when accepted; it gives no
// response beat. A query (cmd 0) reads the first and last valid knots through the
// memory's registered read port, decides the region, and then either returns a constant
// or clamped y at once, or looks the position up in the table. Repeat and mirror modes
// first fold the position through a bit-serial remainder unit when the span is positive
// and there is more than one knot; otherwise they return the clamped y. The lookup scans
// knots 1 to n-2 one memory read per cycle, keeping the highest slot whose x is not above
// the position, then reads the following knot and picks the nearer one, with n the
// effective knot count (count 0 acts as 1, counts above 16 act as 16). The single memory
// read port sets the scan length and the remainder loop sets the fold cost. A finished
// result waits in the output register while the next beat is accepted. Knot slots that
// were never written return undefined values.
module nearest_knot_curve_lookup_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_cmd,
   input  logic        [3:0]                      req_knot_index,
   input  logic signed [nkc_pkg::VAL_W-1:0]       req_x_value,
   input  logic signed [nkc_pkg::VAL_W-1:0]       req_y_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [nkc_pkg::VAL_W-1:0]       rsp_result_value,
   output logic        [1:0]                      rsp_region,
   input  logic                                   csr_wr_en,
   input  logic        [nkc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic        [nkc_pkg::VAL_W-1:0]       csr_wr_data
);

   localparam int IW = nkc_pkg::IDX_W;
   localparam int PW = nkc_pkg::POS_W;
   localparam int CW = nkc_pkg::CMP_W;
   localparam int DW = nkc_pkg::REM_DW;
   localparam int MW = nkc_pkg::REM_MW;

   typedef enum logic [2:0] {
      ST_IDLE, ST_RD0, ST_RDL, ST_REM, ST_LKS, ST_SCAN, ST_PAIR, ST_EMIT
   } state_type;

   state_type state_ff;

   // config registers
   logic [4:0]                        knot_count_ff;
   nkc_pkg::mode_type                 floor_mode_ff;
   nkc_pkg::mode_type                 ceil_mode_ff;
   logic signed [nkc_pkg::VAL_W-1:0]  floor_const_ff;
   logic signed [nkc_pkg::VAL_W-1:0]  ceil_const_ff;

   // query context
   logic signed [nkc_pkg::VAL_W-1:0]  xq_ff;
   logic signed [nkc_pkg::VAL_W-1:0]  x0_ff;
   logic signed [nkc_pkg::VAL_W-1:0]  y0_ff;
   logic signed [nkc_pkg::VAL_W-1:0]  xl_ff;
   logic signed [PW-1:0]              lq_ff;
   logic                              below_ff;
   logic                              mirror_ff;
   logic [IW-1:0]                     p_ff;
   logic signed [nkc_pkg::VAL_W-1:0]  xp_ff;
   logic signed [nkc_pkg::VAL_W-1:0]  yp_ff;
   logic [IW-1:0]                     scan_idx_ff;
   logic                              pend_ff;
   logic [IW-1:0]                     pend_idx_ff;

   // output register
   logic                              rsp_valid_ff;
   logic signed [nkc_pkg::VAL_W-1:0]  rsp_value_ff;
   logic [1:0]                        rsp_region_ff;
   logic signed [nkc_pkg::VAL_W-1:0]  res_ff;
   logic [1:0]                        region_ff;

   // memory and remainder unit hookup
   logic                              wr_en;
   logic [IW-1:0]                     rd_addr;
   logic signed [nkc_pkg::VAL_W-1:0]  rd_x;
   logic signed [nkc_pkg::VAL_W-1:0]  rd_y;
   logic                              rem_start;
   logic signed [DW-1:0]              rem_dividend;
   logic [MW-1:0]                     rem_divisor;
   logic                              rem_done;
   logic signed [DW-1:0]              rem_value;

   logic                              req_fire;
   logic [IW-1:0]                     nm1;
   logic signed [nkc_pkg::VAL_W:0]    span;
   logic signed [nkc_pkg::VAL_W:0]    span_l;
   logic signed [nkc_pkg::VAL_W:0]    offset;
   logic                              is_below;
   logic                              is_above;
   nkc_pkg::mode_type                 act_mode;
   logic                              can_fold;
   logic                              issue;
   logic signed [PW-1:0]              fold_rep;
   logic signed [PW-1:0]              fold_m;
   logic signed [PW-1:0]              fold_r;
   logic signed [PW-1:0]              fold_mir;
   logic signed [CW-1:0]              pair_lhs;
   logic signed [CW-1:0]              pair_rhs;

   // effective knot count minus one, clamped to the table
   always_comb begin
      if (knot_count_ff == 5'd0) begin
         nm1 = '0;
      end else if (32'(knot_count_ff) > nkc_pkg::MAX_KNOTS) begin
         nm1 = IW'(nkc_pkg::MAX_KNOTS - 1);
      end else begin
         nm1 = IW'(knot_count_ff - 5'd1);
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign wr_en     = req_fire && (req_cmd == nkc_pkg::CMD_WRITE)
                      && (32'(req_knot_index) < nkc_pkg::MAX_KNOTS);

   // region decision while the last knot is on the read port
   assign span_l   = (nkc_pkg::VAL_W + 1)'(rd_x) - (nkc_pkg::VAL_W + 1)'(x0_ff);
   assign span     = (nkc_pkg::VAL_W + 1)'(xl_ff) - (nkc_pkg::VAL_W + 1)'(x0_ff);
   assign offset   = (nkc_pkg::VAL_W + 1)'(xq_ff) - (nkc_pkg::VAL_W + 1)'(x0_ff);
   assign is_below = xq_ff < x0_ff;
   assign is_above = !is_below && (xq_ff > rd_x);
   assign act_mode = is_below ? floor_mode_ff : ceil_mode_ff;
   assign can_fold = (nm1 != '0) && (span_l > 0);
   assign issue    = scan_idx_ff < nm1;

   always_comb begin
      case (state_ff)
         ST_RD0:  rd_addr = nm1;
         ST_SCAN: rd_addr = issue ? scan_idx_ff : p_ff + 1'b1;
         default: rd_addr = '0;
      endcase
   end

   // launch the fold: repeat divides d by the span, mirror divides d+span by twice the span
   always_comb begin
      rem_start    = 1'b0;
      rem_dividend = DW'(offset);
      rem_divisor  = MW'(span_l);
      if (state_ff == ST_RDL && (is_below || is_above) && can_fold) begin
         if (act_mode == nkc_pkg::MODE_REPEAT) begin
            rem_start = 1'b1;
         end else if (act_mode == nkc_pkg::MODE_MIRROR) begin
            rem_start    = 1'b1;
            rem_dividend = DW'(offset) + DW'(span_l);
            rem_divisor  = MW'(span_l) << 1;
         end
      end
   end

   // folded positions once the remainder lands
   assign fold_rep = PW'(rem_value) + (below_ff ? PW'(xl_ff) : PW'(x0_ff));
   assign fold_m   = (rem_value < 0) ? PW'(rem_value) + (PW'(span) <<< 1) : PW'(rem_value);
   assign fold_r   = fold_m - PW'(span);
   assign fold_mir = PW'(x0_ff) + ((fold_r < 0) ? -fold_r : fold_r);

   // nearer knot: 2x against xa + xb
   assign pair_lhs = CW'(lq_ff) <<< 1;
   assign pair_rhs = CW'(xp_ff) + CW'(rd_x);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         knot_count_ff  <= 5'd1;
         floor_mode_ff  <= nkc_pkg::MODE_CLAMP;
         ceil_mode_ff   <= nkc_pkg::MODE_CLAMP;
         floor_const_ff <= '0;
         ceil_const_ff  <= '0;
         pend_ff        <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               nkc_pkg::CSR_KNOT_COUNT:     knot_count_ff  <= csr_wr_data[4:0];
               nkc_pkg::CSR_FLOOR_MODE:     floor_mode_ff  <= nkc_pkg::mode_type'(csr_wr_data[1:0]);
               nkc_pkg::CSR_CEIL_MODE:      ceil_mode_ff   <= nkc_pkg::mode_type'(csr_wr_data[1:0]);
               nkc_pkg::CSR_FLOOR_CONSTANT: floor_const_ff <= $signed(csr_wr_data);
               nkc_pkg::CSR_CEIL_CONSTANT:  ceil_const_ff  <= $signed(csr_wr_data);
               default: ;
            endcase
         end

         // drop the response once taken, unless a new one is loaded in its place
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_cmd == nkc_pkg::CMD_QUERY) begin
                  xq_ff    <= req_x_value;
                  state_ff <= ST_RD0;
               end
            end
            ST_RD0: begin
               x0_ff    <= rd_x;
               y0_ff    <= rd_y;
               state_ff <= ST_RDL;
            end
            ST_RDL: begin
               xl_ff    <= rd_x;
               below_ff <= is_below;
               lq_ff    <= PW'(xq_ff);
               if (!is_below && !is_above) begin
                  region_ff <= nkc_pkg::REGION_INSIDE;
                  state_ff  <= ST_LKS;
               end else begin
                  region_ff <= is_below ? nkc_pkg::REGION_BELOW : nkc_pkg::REGION_ABOVE;
                  mirror_ff <= (act_mode == nkc_pkg::MODE_MIRROR);
                  if (act_mode == nkc_pkg::MODE_CONSTANT) begin
                     res_ff   <= is_below ? floor_const_ff : ceil_const_ff;
                     state_ff <= ST_EMIT;
                  end else if (rem_start) begin
                     state_ff <= ST_REM;
                  end else begin
                     res_ff   <= is_below ? y0_ff : rd_y;
                     state_ff <= ST_EMIT;
                  end
               end
            end
            ST_REM: begin
               if (rem_done) begin
                  lq_ff    <= mirror_ff ? fold_mir : fold_rep;
                  state_ff <= ST_LKS;
               end
            end
            ST_LKS: begin
               if (nm1 == '0) begin
                  res_ff   <= y0_ff;
                  state_ff <= ST_EMIT;
               end else begin
                  p_ff        <= '0;
                  xp_ff       <= x0_ff;
                  yp_ff       <= y0_ff;
                  scan_idx_ff <= IW'(1);
                  pend_ff     <= 1'b0;
                  state_ff    <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               // hold the highest slot whose x is not above the position
               if (pend_ff && (PW'(rd_x) <= lq_ff)) begin
                  p_ff  <= pend_idx_ff;
                  xp_ff <= rd_x;
                  yp_ff <= rd_y;
               end
               pend_ff     <= issue;
               pend_idx_ff <= scan_idx_ff;
               if (issue) begin
                  scan_idx_ff <= scan_idx_ff + 1'b1;
               end else if (!pend_ff) begin
                  state_ff <= ST_PAIR;
               end
            end
            ST_PAIR: begin
               res_ff   <= (pair_lhs < pair_rhs) ? yp_ff : rd_y;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_value_ff  <= res_ff;
                  rsp_region_ff <= region_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   nkc_knot_ram u_knot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IW'(req_knot_index)),
      .wr_x    (req_x_value),
      .wr_y    (req_y_value),
      .rd_addr (rd_addr),
      .rd_x    (rd_x),
      .rd_y    (rd_y)
   );

   nkc_rem_unit u_rem_unit (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rem_dividend),
      .divisor   (rem_divisor),
      .done      (rem_done),
      .remainder (rem_value)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_region       = rsp_region_ff;

endmodule
